>>> src/preemptive_priority_scheduler_aging_macros.svh
// assertion macros for the priority scheduler checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_AGING_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_AGING_MACROS_SVH

// implication checked in the same cycle
`define PPSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// implication checked in the next cycle
`define PPSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

>>> src/ppsa_pkg.sv
// shared types and codes of the priority scheduler
`timescale 1ns / 1ps
`default_nettype none
package ppsa_pkg;

	localparam logic [9:0] PRIO_MAX = 10'd1023;

	typedef struct packed {
		logic [7:0]  id;
		logic [9:0]  prio;
		logic [15:0] left;
	} task_t;

	typedef enum logic [2:0] {
		OP_ADD, OP_ADMIT, OP_START, OP_TICK, OP_SUSP_READY, OP_SUSP_RUN, OP_RESUME, OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		ST_OK, ST_BACKLOG_FULL, ST_ZERO_PRIO, ST_NOT_FOUND, ST_DROPPED
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_LATCH, ACT_EXEC, ACT_ADM_WR, ACT_SORT, ACT_PREEMPT, ACT_RUNDOWN, ACT_AGE
	} act_t;

	typedef struct packed {
		act_t act;
		logic odd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic adm_go;
		logic pre_go;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> src/preemptive_priority_scheduler_aging.sv
// Preemptive priority scheduler with aging, one word in and one result word out per operation.
// The block takes one operation at a time. Add, start, suspend and nop go from the execute
// state straight to the result; resume adds a re-sort of the ready table; admit and tick
// first move tasks from the backlog, each with a registered read of the backlog memory and
// a write into the ready table, and then re-sort; tick may then preempt and re-sort again,
// runs down the processor task and ages the waiting ones. A re-sort is READY_SLOTS
// odd-even transposition phases over the ready table. A finished result sits in
// the output register until taken; a new word is accepted only once the previous result
// has been loaded there.
`timescale 1ns / 1ps
`default_nettype none
module preemptive_priority_scheduler_aging
	import ppsa_pkg::*;
#(
	parameter int READY_SLOTS   = 6,
	parameter int BACKLOG_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  proc_id,
	input  wire logic [9:0]  prio_in,
	input  wire logic [15:0] run_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             running_valid,
	output logic [7:0]       running_id,
	output logic [9:0]       running_prio,
	output logic [15:0]      running_left,
	output logic             finished_valid,
	output logic [7:0]       finished_id,
	output logic             preempted,
	output logic [4:0]       ready_count,
	output logic [7:0]       backlog_count,
	output logic [2:0]       status
);
	cmd_t  cmd;
	stat_t stat;

	// operation sequencer
	ppsa_ctrl #(.READY_SLOTS(READY_SLOTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	// tables, backlog and result word
	ppsa_dp #(.READY_SLOTS(READY_SLOTS), .BACKLOG_DEPTH(BACKLOG_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.opcode(opcode), .proc_id(proc_id), .prio_in(prio_in), .run_in(run_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.running_valid(running_valid), .running_id(running_id),
		.running_prio(running_prio), .running_left(running_left),
		.finished_valid(finished_valid), .finished_id(finished_id),
		.preempted(preempted), .ready_count(ready_count),
		.backlog_count(backlog_count), .status(status)
	);

endmodule
`default_nettype wire

>>> src/ppsa_dp.sv
// scheduler datapath: task tables, backlog memory, processor task and result word
`timescale 1ns / 1ps
`default_nettype none
module ppsa_dp
	import ppsa_pkg::*;
#(
	parameter int READY_SLOTS   = 6,
	parameter int BACKLOG_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  proc_id,
	input  wire logic [9:0]  prio_in,
	input  wire logic [15:0] run_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             running_valid,
	output logic [7:0]       running_id,
	output logic [9:0]       running_prio,
	output logic [15:0]      running_left,
	output logic             finished_valid,
	output logic [7:0]       finished_id,
	output logic             preempted,
	output logic [4:0]       ready_count,
	output logic [7:0]       backlog_count,
	output logic [2:0]       status
);
	localparam int SW = $clog2(READY_SLOTS);
	localparam int CW = $clog2(READY_SLOTS + 1);
	localparam int BW = $clog2(BACKLOG_DEPTH);
	localparam int FW = $clog2(BACKLOG_DEPTH + 1);

	task_t rdy_q [READY_SLOTS];
	task_t held_q [READY_SLOTS];
	task_t rdy_n [READY_SLOTS];
	task_t held_n [READY_SLOTS];
	task_t rm0 [READY_SLOTS];
	task_t rmk [READY_SLOTS];
	task_t cpu_q, cpu_n, rdk, hdk;
	task_t bl_mem [BACKLOG_DEPTH];
	task_t bl_rd_q;
	logic [BW-1:0] head_q, tail_q;
	logic [FW-1:0] fill_q, fill_n;
	logic [CW-1:0] res_q, res_n, occ;
	logic bl_we, head_inc;
	op_t op_q;
	logic [7:0] id_q;
	logic [9:0] prio_q, p_run_q, p_head_q;
	logic [15:0] run_q;
	logic fin_q, fin_n, pre_q, pre_n;
	logic [7:0] fin_id_q, fin_id_n;
	status_t st_q, st_n;
	logic [SW-1:0] rf, rk, hk, hs, ins;
	logic rf_ok, rk_ok, hk_ok, hs_ok;

	// slot searches and occupancy
	always_comb begin
		rf = '0; rk = '0; hk = '0; hs = '0;
		rf_ok = 1'b0; rk_ok = 1'b0; hk_ok = 1'b0; hs_ok = 1'b0;
		occ = '0;
		for (int i = 0; i < READY_SLOTS; i++) begin
			if (rdy_q[i].prio != '0) occ = occ + CW'(1);
			if (!rf_ok && rdy_q[i].prio == '0) begin
				rf = SW'(i); rf_ok = 1'b1;
			end
			if (!rk_ok && rdy_q[i].prio != '0 && rdy_q[i].id == id_q) begin
				rk = SW'(i); rk_ok = 1'b1;
			end
			if (!hk_ok && held_q[i].prio != '0 && held_q[i].id == id_q) begin
				hk = SW'(i); hk_ok = 1'b1;
			end
			if (!hs_ok && held_q[i].prio == '0) begin
				hs = SW'(i); hs_ok = 1'b1;
			end
		end
		ins = rf_ok ? rf - SW'(1) : SW'(READY_SLOTS - 1);
		rdk = rdy_q[rk];
		hdk = held_q[hk];
	end

	// ready table with the head or a matched slot taken out and the rest packed
	always_comb begin
		for (int i = 0; i < READY_SLOTS; i++) begin
			if (i < READY_SLOTS - 1) rm0[i] = rdy_q[i + 1];
			else rm0[i] = '0;
			if (SW'(i) >= rk) rmk[i] = rm0[i];
			else rmk[i] = rdy_q[i];
		end
	end

	assign stat.op = op_q;
	assign stat.adm_go = (res_q < CW'(READY_SLOTS)) && (fill_q != '0) && rf_ok;
	assign stat.pre_go = p_head_q > p_run_q;
	assign stat.out_free = !out_valid || out_ready;

	// next state of tables and processor
	always_comb begin
		rdy_n = rdy_q; held_n = held_q; cpu_n = cpu_q;
		fill_n = fill_q; res_n = res_q;
		fin_n = fin_q; fin_id_n = fin_id_q; pre_n = pre_q; st_n = st_q;
		bl_we = 1'b0; head_inc = 1'b0;
		unique case (cmd.act)
			ACT_NONE: begin
			end
			ACT_LATCH: begin
				fin_n = 1'b0; fin_id_n = '0; pre_n = 1'b0; st_n = ST_OK;
			end
			ACT_EXEC: begin
				unique case (op_q)
					OP_ADD: begin
						if (prio_q == '0) st_n = ST_ZERO_PRIO;
						else if (fill_q == FW'(BACKLOG_DEPTH)) st_n = ST_BACKLOG_FULL;
						else begin
							bl_we = 1'b1;
							fill_n = fill_q + FW'(1);
						end
					end
					OP_START: begin
						if (cpu_q.prio == '0) begin
							cpu_n = rdy_q[0];
							if (rdy_q[0].prio != '0) rdy_n = rm0;
						end
					end
					OP_SUSP_READY: begin
						if (!rk_ok) st_n = ST_NOT_FOUND;
						else if (!hs_ok) st_n = ST_DROPPED;
						else begin
							held_n[hs] = rdk;
							rdy_n = rmk;
						end
					end
					OP_SUSP_RUN: begin
						if (cpu_q.prio == '0) st_n = ST_NOT_FOUND;
						else if (!hs_ok) st_n = ST_DROPPED;
						else begin
							held_n[hs] = cpu_q;
							cpu_n = rdy_q[0];
							if (rdy_q[0].prio != '0) rdy_n = rm0;
						end
					end
					OP_RESUME: begin
						if (!hk_ok) st_n = ST_NOT_FOUND;
						else if (!rf_ok) st_n = ST_DROPPED;
						else begin
							rdy_n[rf] = hdk;
							held_n[hk] = '0;
						end
					end
					OP_ADMIT, OP_TICK, OP_NOP: begin
					end
					default: begin
					end
				endcase
			end
			ACT_ADM_WR: begin
				rdy_n[rf] = bl_rd_q;
				head_inc = 1'b1;
				fill_n = fill_q - FW'(1);
				res_n = res_q + CW'(1);
			end
			ACT_SORT: begin
				// one odd-even transposition phase
				for (int j = 0; j < READY_SLOTS - 1; j++) begin
					if ((j % 2 == 1) == cmd.odd && rdy_q[j].prio < rdy_q[j + 1].prio) begin
						rdy_n[j] = rdy_q[j + 1];
						rdy_n[j + 1] = rdy_q[j];
					end
				end
			end
			ACT_PREEMPT: begin
				cpu_n = rdy_q[0];
				rdy_n = rm0;
				if (p_run_q != '0) begin
					rdy_n[ins] = cpu_q;
					pre_n = 1'b1;
				end
			end
			ACT_RUNDOWN: begin
				if (cpu_q.prio != '0 && cpu_q.left > 16'd1) begin
					cpu_n.prio = (cpu_q.prio > 10'd1) ? cpu_q.prio - 10'd1 : 10'd1;
					cpu_n.left = cpu_q.left - 16'd1;
				end else begin
					if (cpu_q.prio != '0) begin
						fin_n = 1'b1;
						fin_id_n = cpu_q.id;
						if (res_q != '0) res_n = res_q - CW'(1);
					end
					cpu_n = rdy_q[0];
					if (rdy_q[0].prio != '0) rdy_n = rm0;
				end
			end
			ACT_AGE: begin
				for (int i = 0; i < READY_SLOTS; i++)
					if (rdy_q[i].prio != '0 && rdy_q[i].prio < PRIO_MAX)
						rdy_n[i].prio = rdy_q[i].prio + 10'd1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < READY_SLOTS; i++) begin
				rdy_q[i] <= '0;
				held_q[i] <= '0;
			end
			cpu_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			res_q <= '0;
			out_valid <= 1'b0;
		end else begin
			rdy_q <= rdy_n;
			held_q <= held_n;
			cpu_q <= cpu_n;
			fill_q <= fill_n;
			res_q <= res_n;
			if (bl_we) tail_q <= (tail_q == BW'(BACKLOG_DEPTH - 1)) ? '0 : tail_q + BW'(1);
			if (head_inc) head_q <= (head_q == BW'(BACKLOG_DEPTH - 1)) ? '0 : head_q + BW'(1);
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// backlog memory, registered read of the head
	always_ff @(posedge clk) begin
		if (bl_we) bl_mem[tail_q] <= '{id: id_q, prio: prio_q, left: run_q};
		bl_rd_q <= bl_mem[head_q];
	end

	// input word, tick snapshot, flags and result word
	always_ff @(posedge clk) begin
		if (cmd.act == ACT_LATCH) begin
			op_q <= op_t'(opcode);
			id_q <= proc_id;
			prio_q <= prio_in;
			run_q <= run_in;
			p_run_q <= cpu_q.prio;
			p_head_q <= rdy_q[0].prio;
		end
		fin_q <= fin_n;
		fin_id_q <= fin_id_n;
		pre_q <= pre_n;
		st_q <= st_n;
		if (cmd.out_load) begin
			running_valid <= cpu_q.prio != '0;
			running_id <= cpu_q.id;
			running_prio <= cpu_q.prio;
			running_left <= cpu_q.left;
			finished_valid <= fin_q;
			finished_id <= fin_id_q;
			preempted <= pre_q;
			ready_count <= 5'(occ);
			backlog_count <= 8'(fill_q);
			status <= st_q;
		end
	end

endmodule
`default_nettype wire

>>> src/ppsa_ctrl.sv
// scheduler controller: sequences each operation over the datapath
`timescale 1ns / 1ps
`default_nettype none
module ppsa_ctrl
	import ppsa_pkg::*;
#(
	parameter int READY_SLOTS = 6
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);
	localparam int CW = $clog2(READY_SLOTS + 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_EXEC   = 9'b000000010,
		S_ADM    = 9'b000000100,
		S_ADM_WR = 9'b000001000,
		S_SORT   = 9'b000010000,
		S_PRE    = 9'b000100000,
		S_RUN    = 9'b001000000,
		S_AGE    = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_n;
	logic [CW-1:0] sort_q, sort_n;
	logic post_pre_q, post_pre_n;

	assign in_ready = state_q == S_IDLE;

	// next state and commands
	always_comb begin
		state_n = state_q;
		sort_n = sort_q;
		post_pre_n = post_pre_q;
		cmd.act = ACT_NONE;
		cmd.odd = sort_q[0];
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.act = ACT_LATCH;
					post_pre_n = 1'b0;
					sort_n = '0;
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.act = ACT_EXEC;
				if (stat.op == OP_ADMIT || stat.op == OP_TICK) state_n = S_ADM;
				else if (stat.op == OP_RESUME) state_n = S_SORT;
				else state_n = S_FIN;
			end
			S_ADM: begin
				if (stat.adm_go) state_n = S_ADM_WR;
				else state_n = S_SORT;
			end
			S_ADM_WR: begin
				cmd.act = ACT_ADM_WR;
				state_n = S_ADM;
			end
			S_SORT: begin
				cmd.act = ACT_SORT;
				if (sort_q == CW'(READY_SLOTS - 1)) begin
					sort_n = '0;
					if (stat.op != OP_TICK) state_n = S_FIN;
					else if (!post_pre_q && stat.pre_go) state_n = S_PRE;
					else state_n = S_RUN;
				end else begin
					sort_n = sort_q + CW'(1);
				end
			end
			S_PRE: begin
				cmd.act = ACT_PREEMPT;
				post_pre_n = 1'b1;
				state_n = S_SORT;
			end
			S_RUN: begin
				cmd.act = ACT_RUNDOWN;
				state_n = S_AGE;
			end
			S_AGE: begin
				cmd.act = ACT_AGE;
				state_n = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sort_q <= '0;
			post_pre_q <= 1'b0;
		end else begin
			state_q <= state_n;
			sort_q <= sort_n;
			post_pre_q <= post_pre_n;
		end
	end

endmodule
`default_nettype wire

>>> src/ppsa_checker.sv
// port checker for the priority scheduler and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "preemptive_priority_scheduler_aging_macros.svh"
module ppsa_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       running_valid,
	input wire logic [7:0] running_id,
	input wire logic [9:0] running_prio,
	input wire logic       finished_valid,
	input wire logic [7:0] finished_id
);
	// a held result word stays valid and keeps its running id
	`PPSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(running_id))
	// one operation at a time: busy right after a word is taken
	`PPSA_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
	// an idle processor reports a cleared task
	`PPSA_ASSERT_NOW(a_idle_cpu, out_valid && !running_valid, running_id == 8'd0 && running_prio == 10'd0)
	// no finish, no finished id
	`PPSA_ASSERT_NOW(a_fin_id, out_valid && !finished_valid, finished_id == 8'd0)
endmodule

bind preemptive_priority_scheduler_aging ppsa_checker u_ppsa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .running_valid(running_valid),
	.running_id(running_id), .running_prio(running_prio),
	.finished_valid(finished_valid), .finished_id(finished_id)
);
`default_nettype wire

>>> dv/tb_preemptive_priority_scheduler_aging.sv
// self-checking testbench for the preemptive priority scheduler with aging
`timescale 1ns / 1ps
module tb_preemptive_priority_scheduler_aging;
	import ppsa_pkg::*;

	localparam int SLOTS      = 6;
	localparam int DEPTH      = 128;
	localparam int STALL_MAX  = 5000;

	typedef struct {
		logic        rv;
		logic [7:0]  rid;
		logic [9:0]  rprio;
		logic [15:0] rleft;
		logic        fv;
		logic [7:0]  fid;
		logic        pre;
		logic [4:0]  rcnt;
		logic [7:0]  bcnt;
		logic [2:0]  st;
	} sched_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = 3'd0;
	logic [7:0]  proc_id = 8'd0;
	logic [9:0]  prio_in = 10'd0;
	logic [15:0] run_in = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        running_valid;
	logic [7:0]  running_id;
	logic [9:0]  running_prio;
	logic [15:0] running_left;
	logic        finished_valid;
	logic [7:0]  finished_id;
	logic        preempted;
	logic [4:0]  ready_count;
	logic [7:0]  backlog_count;
	logic [2:0]  status;

	// scheduler state mirror
	task_t       rdy_tbl [SLOTS];
	task_t       held_tbl [SLOTS];
	task_t       backlog_mem [DEPTH];
	int          bl_head, bl_fill, resident;
	task_t       cpu;
	sched_word_t sched_expected [$];

	int idle_pct, stall_pct, err_cnt, quiet_cycles;

	preemptive_priority_scheduler_aging u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .proc_id(proc_id), .prio_in(prio_in), .run_in(run_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.running_valid(running_valid), .running_id(running_id),
		.running_prio(running_prio), .running_left(running_left),
		.finished_valid(finished_valid), .finished_id(finished_id),
		.preempted(preempted), .ready_count(ready_count),
		.backlog_count(backlog_count), .status(status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ready table helpers
	function automatic int free_ready();
		for (int i = 0; i < SLOTS; i++)
			if (rdy_tbl[i].prio == 0) return i;
		return -1;
	endfunction

	function automatic void drop_ready(int k);
		for (int i = k; i < SLOTS - 1; i++) rdy_tbl[i] = rdy_tbl[i + 1];
		rdy_tbl[SLOTS - 1] = '0;
	endfunction

	// stable descending order by priority
	function automatic void order_ready();
		task_t t;
		for (int i = 0; i < SLOTS - 1; i++)
			for (int j = 0; j < SLOTS - 1 - i; j++)
				if (rdy_tbl[j].prio < rdy_tbl[j + 1].prio) begin
					t = rdy_tbl[j];
					rdy_tbl[j] = rdy_tbl[j + 1];
					rdy_tbl[j + 1] = t;
				end
	endfunction

	function automatic void admit_backlog();
		int s;
		while (resident < SLOTS && bl_fill > 0) begin
			s = free_ready();
			if (s < 0) break;
			rdy_tbl[s] = backlog_mem[bl_head];
			bl_head = (bl_head + 1) % DEPTH;
			bl_fill--;
			resident++;
		end
		order_ready();
	endfunction

	function automatic void dispatch();
		cpu = rdy_tbl[0];
		if (rdy_tbl[0].prio != 0) drop_ready(0);
	endfunction

	function automatic int free_held();
		for (int i = 0; i < SLOTS; i++)
			if (held_tbl[i].prio == 0) return i;
		return -1;
	endfunction

	// apply one operation to the mirror and return the word it must produce
	function automatic sched_word_t schedule_step(op_t op, logic [7:0] pid, logic [9:0] pr,
			logic [15:0] rn);
		sched_word_t w;
		int k, s, occ;
		logic [9:0] p_run, p_head;
		task_t head;
		w = '{default: '0};
		w.st = ST_OK;
		case (op)
			OP_ADD: begin
				if (pr == 0) w.st = ST_ZERO_PRIO;
				else if (bl_fill >= DEPTH) w.st = ST_BACKLOG_FULL;
				else begin
					backlog_mem[(bl_head + bl_fill) % DEPTH] = '{id: pid, prio: pr, left: rn};
					bl_fill++;
				end
			end
			OP_ADMIT: admit_backlog();
			OP_START: if (cpu.prio == 0) dispatch();
			OP_TICK: begin
				p_run = cpu.prio;
				p_head = rdy_tbl[0].prio;
				admit_backlog();
				if (p_head > p_run) begin
					head = rdy_tbl[0];
					drop_ready(0);
					if (p_run != 0) begin
						s = free_ready();
						if (s >= 0) rdy_tbl[s] = cpu;
						w.pre = 1'b1;
					end
					order_ready();
					cpu = head;
				end
				if (cpu.prio != 0 && cpu.left > 1) begin
					cpu.prio = (cpu.prio > 1) ? cpu.prio - 1 : 10'd1;
					cpu.left = cpu.left - 1;
				end else begin
					if (cpu.prio != 0) begin
						w.fv = 1'b1;
						w.fid = cpu.id;
						if (resident > 0) resident--;
					end
					dispatch();
				end
				// aging of waiting tasks
				for (int i = 0; i < SLOTS; i++)
					if (rdy_tbl[i].prio != 0 && rdy_tbl[i].prio < PRIO_MAX)
						rdy_tbl[i].prio++;
			end
			OP_SUSP_READY: begin
				k = -1;
				for (int i = 0; i < SLOTS; i++)
					if (k < 0 && rdy_tbl[i].prio != 0 && rdy_tbl[i].id == pid) k = i;
				if (k < 0) w.st = ST_NOT_FOUND;
				else begin
					s = free_held();
					if (s < 0) w.st = ST_DROPPED;
					else begin
						held_tbl[s] = rdy_tbl[k];
						drop_ready(k);
					end
				end
			end
			OP_SUSP_RUN: begin
				if (cpu.prio == 0) w.st = ST_NOT_FOUND;
				else begin
					s = free_held();
					if (s < 0) w.st = ST_DROPPED;
					else begin
						held_tbl[s] = cpu;
						dispatch();
					end
				end
			end
			OP_RESUME: begin
				k = -1;
				for (int i = 0; i < SLOTS; i++)
					if (k < 0 && held_tbl[i].prio != 0 && held_tbl[i].id == pid) k = i;
				if (k < 0) w.st = ST_NOT_FOUND;
				else begin
					s = free_ready();
					if (s < 0) w.st = ST_DROPPED;
					else begin
						rdy_tbl[s] = held_tbl[k];
						held_tbl[k] = '0;
						order_ready();
					end
				end
			end
			default: ;
		endcase
		if (cpu.prio == 0) cpu = '0;
		occ = 0;
		for (int i = 0; i < SLOTS; i++)
			if (rdy_tbl[i].prio != 0) occ++;
		w.rv = (cpu.prio != 0);
		w.rid = cpu.id;
		w.rprio = cpu.prio;
		w.rleft = cpu.left;
		w.rcnt = occ[4:0];
		w.bcnt = bl_fill[7:0];
		return w;
	endfunction

	// send one word; valid stays high across back-to-back words
	task automatic send_op(op_t op, logic [7:0] pid = 8'd0, logic [9:0] pr = 10'd1,
			logic [15:0] rn = 16'd1);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		proc_id <= pid;
		prio_in <= pr;
		run_in <= rn;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sched_expected.push_back(schedule_step(op, pid, pr, rn));
	endtask

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		sched_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (sched_expected.size() == 0) begin
				$error("result word with nothing expected");
				err_cnt++;
			end else begin
				w = sched_expected.pop_front();
				check_field("running_valid", w.rv, running_valid);
				check_field("running_id", w.rid, running_id);
				check_field("running_prio", w.rprio, running_prio);
				check_field("running_left", w.rleft, running_left);
				check_field("finished_valid", w.fv, finished_valid);
				check_field("finished_id", w.fid, finished_id);
				check_field("preempted", w.pre, preempted);
				check_field("ready_count", w.rcnt, ready_count);
				check_field("backlog_count", w.bcnt, backlog_count);
				check_field("status", w.st, status);
			end
		end
		out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// watchdog on stuck handshakes
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_add_limits();
		send_op(OP_ADD, 8'd0, 10'd0, 16'd5);
		send_op(OP_ADD, 8'd255, 10'd1023, 16'd20);
		send_op(OP_ADD, 8'd0, 10'd1, 16'd0);
		send_op(OP_ADD, 8'd170, 10'd512, 16'd1);
		send_op(OP_ADD, 8'd85, 10'd341, 16'd10);
		send_op(OP_NOP, 8'd255, 10'd1023, 16'd65535);
	endtask

	task automatic test_start_tick();
		send_op(OP_START);
		send_op(OP_TICK);
		send_op(OP_ADMIT);
		send_op(OP_START);
		send_op(OP_START);
		repeat (4) send_op(OP_TICK);
		send_op(OP_SUSP_RUN);
		send_op(OP_SUSP_READY, 8'd0);
		send_op(OP_SUSP_READY, 8'd99);
		send_op(OP_RESUME, 8'd99);
		send_op(OP_RESUME, 8'd255);
		send_op(OP_RESUME, 8'd0);
		send_op(OP_RESUME, 8'd170);
		repeat (3) send_op(OP_TICK);
	endtask

	// priority floor of a long runner, saturation of a waiting task
	task automatic test_floor_and_aging();
		while (cpu.prio != 0 || rdy_tbl[0].prio != 0 || bl_fill != 0)
			send_op(OP_TICK);
		send_op(OP_ADD, 8'd7, 10'd2, 16'd8);
		send_op(OP_TICK);
		send_op(OP_ADD, 8'd8, 10'd1023, 16'd3);
		send_op(OP_ADD, 8'd9, 10'd1022, 16'd2);
		repeat (8) send_op(OP_TICK);
		send_op(OP_SUSP_RUN);
		send_op(OP_SUSP_RUN);
	endtask

	task automatic test_backlog_full();
		while (resident != 0) begin
			if (cpu.prio == 0 && held_tbl[0].prio == 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (held_tbl[i].prio != 0) send_op(OP_RESUME, held_tbl[i].id);
			end
			for (int i = 0; i < SLOTS; i++)
				if (held_tbl[i].prio != 0) send_op(OP_RESUME, held_tbl[i].id);
			send_op(OP_TICK);
		end
		for (int i = 0; i <= DEPTH; i++)
			send_op(OP_ADD, i[7:0], 10'($urandom_range(1, 1023)), 16'($urandom_range(0, 2)));
		send_op(OP_ADD, 8'd1, 10'd0, 16'd1);
		while (bl_fill > 0 || resident > 0) send_op(OP_TICK);
	endtask

	function automatic logic [7:0] pick_id(bit from_held);
		int n;
		task_t t;
		n = $urandom_range(SLOTS - 1);
		t = from_held ? held_tbl[n] : rdy_tbl[n];
		if ($urandom_range(9) < 8 && t.prio != 0) return t.id;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_random(int count);
		int r;
		logic [9:0] pr;
		logic [15:0] rn;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			pr = ($urandom_range(9) == 0) ? 10'($urandom_range(0, 1) * 1023) :
				10'($urandom_range(0, 1023));
			rn = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 65535)) :
				16'($urandom_range(0, 6));
			if (r < 28)
				send_op(OP_ADD, ($urandom_range(1)) ? 8'($urandom_range(0, 15)) :
					8'($urandom_range(0, 255)), pr, rn);
			else if (r < 36) send_op(OP_ADMIT);
			else if (r < 44) send_op(OP_START);
			else if (r < 74) send_op(OP_TICK);
			else if (r < 83) send_op(OP_SUSP_READY, pick_id(1'b0));
			else if (r < 89) send_op(OP_SUSP_RUN);
			else if (r < 98) send_op(OP_RESUME, pick_id(1'b1));
			else send_op(OP_NOP, 8'($urandom_range(0, 255)), pr, rn);
		end
	endtask

	// reset, then the directed and random phases under varying idling and receiver stall
	initial begin
		err_cnt = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		bl_head = 0;
		bl_fill = 0;
		resident = 0;
		cpu = '0;
		for (int i = 0; i < SLOTS; i++) begin
			rdy_tbl[i] = '0;
			held_tbl[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_add_limits();
		test_start_tick();
		test_floor_and_aging();
		idle_pct = 72;
		test_backlog_full();
		idle_pct = 0;
		test_random(300);
		idle_pct = 72;
		test_random(250);
		idle_pct = 0;
		stall_pct = 72;
		test_random(250);
		idle_pct = 12;
		stall_pct = 12;
		test_random(250);
		idle_pct = 0;
		stall_pct = 0;
		in_valid <= 1'b0;
		while (sched_expected.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> preemptive_priority_scheduler_aging.f
+incdir+src
src/ppsa_pkg.sv
src/ppsa_dp.sv
src/ppsa_ctrl.sv
src/preemptive_priority_scheduler_aging.sv
src/ppsa_checker.sv
dv/tb_preemptive_priority_scheduler_aging.sv
